### rtl/vcfp_pkg.sv
`default_nettype none

package vcfp_pkg;

    localparam int unsigned BYTE_W      = 8;
    localparam int unsigned WORD_W      = 32;
    localparam int unsigned FRAME_BYTES = 13;
    localparam int unsigned HIST_BYTES  = FRAME_BYTES - 1;
    localparam int unsigned FILL_W      = 4;
    localparam int unsigned CFG_INDEX_W = 2;
    localparam int unsigned CFG_DATA_W  = 8;

    localparam int unsigned FUNC_POS   = 1;
    localparam int unsigned LEN_POS    = 2;
    localparam int unsigned LIN_POS    = 3;
    localparam int unsigned ANG_POS    = 7;
    localparam int unsigned SUM_LAST   = 10;
    localparam int unsigned CHECK_POS  = 11;
    localparam int unsigned FOOTER_POS = 12;

    localparam logic [BYTE_W-1:0] HEADER_RESET   = 8'd170;
    localparam logic [BYTE_W-1:0] FUNCTION_RESET = 8'd1;
    localparam logic [BYTE_W-1:0] LENGTH_RESET   = 8'd8;
    localparam logic [BYTE_W-1:0] FOOTER_RESET   = 8'd85;

    typedef logic [BYTE_W-1:0] byte_t;
    typedef logic [WORD_W-1:0] word_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_HEADER   = 2'd0,
        CFG_FUNCTION = 2'd1,
        CFG_LENGTH   = 2'd2,
        CFG_FOOTER   = 2'd3
    } cfg_index_t;

endpackage

`default_nettype wire

### rtl/vcfp_rx_if.sv
`default_nettype none

interface vcfp_rx_if
    import vcfp_pkg::*;
;
    logic  valid;
    logic  ready;
    byte_t rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink (input valid, input rx_byte, output ready);
endinterface

`default_nettype wire

### rtl/vcfp_cmd_if.sv
`default_nettype none

interface vcfp_cmd_if
    import vcfp_pkg::*;
;
    logic  valid;
    logic  ready;
    word_t linear_word;
    word_t angular_word;

    modport source (output valid, output linear_word, output angular_word, input ready);
    modport sink (input valid, input linear_word, input angular_word, output ready);
endinterface

`default_nettype wire

### rtl/velocity_command_frame_parser.sv
// channel   dir  transaction               payload
// rx        in   one received byte         rx_byte[7:0]
// cmd       out  one accepted frame        linear_word[31:0], angular_word[31:0]
// cfg       in   register write, no wait   cfg_index[1:0], cfg_wdata[7:0]
//
// one byte per cycle sustained while the result is not stalled; a byte is
// registered, then checked against the last 12 bytes in the following cycle
// and the frame result is registered
// reset empties the byte history and loads the default match bytes
// a stalled result holds the check stage; rx ready drops only while both the
// check stage and the result register are occupied
`default_nettype none

module velocity_command_frame_parser
    import vcfp_pkg::*;
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    vcfp_rx_if.sink                     rx,
    vcfp_cmd_if.source                  cmd,
    input  wire logic                   cfg_we,
    input  wire logic [CFG_INDEX_W-1:0] cfg_index,
    input  wire logic [CFG_DATA_W-1:0]  cfg_wdata
);

    byte_t header_reg;
    byte_t function_reg;
    byte_t length_reg;
    byte_t footer_reg;

    logic  in_valid_reg;
    byte_t in_byte_reg;

    byte_t             hist_reg [HIST_BYTES];
    logic [FILL_W-1:0] fill_reg;
    logic [FILL_W-1:0] fill_next;

    logic  out_valid_reg;
    logic  out_valid_next;
    word_t linear_reg;
    word_t angular_reg;

    byte_t frame [FRAME_BYTES];
    byte_t sum;
    logic  full;
    logic  match;
    logic  advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            header_reg   <= HEADER_RESET;
            function_reg <= FUNCTION_RESET;
            length_reg   <= LENGTH_RESET;
            footer_reg   <= FOOTER_RESET;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_HEADER:   header_reg   <= cfg_wdata;
                CFG_FUNCTION: function_reg <= cfg_wdata;
                CFG_LENGTH:   length_reg   <= cfg_wdata;
                CFG_FOOTER:   footer_reg   <= cfg_wdata;
                default:      ;
            endcase
        end
    end

    assign advance  = in_valid_reg && (!out_valid_reg || cmd.ready);
    assign rx.ready = !in_valid_reg || advance;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (rx.ready)
        begin
            in_valid_reg <= rx.valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rx.valid && rx.ready)
        begin
            in_byte_reg <= rx.rx_byte;
        end
    end

    always_comb
    begin
        for (int k = 0; k < HIST_BYTES; k++)
        begin
            frame[k] = hist_reg[k];
        end
        frame[FOOTER_POS] = in_byte_reg;
    end

    always_comb
    begin
        sum = '0;
        for (int k = FUNC_POS; k <= SUM_LAST; k++)
        begin
            sum = sum + frame[k];
        end
    end

    assign full  = (fill_reg == FILL_W'(HIST_BYTES));
    assign match = (frame[0] == header_reg) && (frame[FUNC_POS] == function_reg)
                && (frame[LEN_POS] == length_reg) && (frame[FOOTER_POS] == footer_reg)
                && (sum == frame[CHECK_POS]);

    always_comb
    begin
        fill_next = fill_reg;
        if (advance)
        begin
            if (!full)
            begin
                fill_next = fill_reg + FILL_W'(1);
            end
            else if (match)
            begin
                fill_next = '0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fill_reg <= '0;
        end
        else
        begin
            fill_reg <= fill_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            for (int k = 0; k < HIST_BYTES - 1; k++)
            begin
                hist_reg[k] <= hist_reg[k + 1];
            end
            hist_reg[HIST_BYTES - 1] <= in_byte_reg;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !cmd.ready;
        if (advance && full && match)
        begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance && full && match)
        begin
            linear_reg  <= {frame[LIN_POS + 3], frame[LIN_POS + 2],
                            frame[LIN_POS + 1], frame[LIN_POS]};
            angular_reg <= {frame[ANG_POS + 3], frame[ANG_POS + 2],
                            frame[ANG_POS + 1], frame[ANG_POS]};
        end
    end

    assign cmd.valid        = out_valid_reg;
    assign cmd.linear_word  = linear_reg;
    assign cmd.angular_word = angular_reg;

endmodule

`default_nettype wire

### rtl/vcfp_checker.sv
`default_nettype none

module vcfp_checker
    import vcfp_pkg::*;
(
    input wire logic  clk,
    input wire logic  rst_n,
    input wire logic  rx_valid,
    input wire logic  rx_ready,
    input wire logic  cmd_valid,
    input wire logic  cmd_ready,
    input wire word_t cmd_linear_word,
    input wire word_t cmd_angular_word
);

    a_cmd_valid_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> cmd_valid)
        else $error("cmd valid dropped while stalled");

    a_cmd_payload_holds: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && !cmd_ready |=> $stable(cmd_linear_word) && $stable(cmd_angular_word))
        else $error("cmd payload changed while stalled");

    a_rx_stall_only_on_cmd_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !rx_ready |-> cmd_valid && !cmd_ready)
        else $error("rx stalled without a pending cmd transaction");

    a_cmd_follows_rx: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(cmd_valid) |-> $past(rx_valid && rx_ready, 2))
        else $error("cmd transaction without rx transaction two cycles earlier");

endmodule

bind velocity_command_frame_parser vcfp_checker u_vcfp_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .rx_valid         (rx.valid),
    .rx_ready         (rx.ready),
    .cmd_valid        (cmd.valid),
    .cmd_ready        (cmd.ready),
    .cmd_linear_word  (cmd.linear_word),
    .cmd_angular_word (cmd.angular_word)
);

`default_nettype wire
